// ----- src/vss_pkg.sv -----
`default_nettype none

package vss_pkg;

   localparam int GRID_X_DEFAULT = 32;
   localparam int GRID_Y_DEFAULT = 32;
   localparam int GRID_Z_DEFAULT = 32;
   localparam int ADDR_W_DEFAULT = 15;

   localparam int MODE_W      = 4;
   localparam int COORD_W     = 8;
   localparam int RADIUS_W    = 6;
   localparam int CHAN_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // signed compare width for grid coordinates against 8-bit signed bounds
   localparam int CMP_W = COORD_W + 1;
   // multiplier operand width and accumulator width of the quadric terms
   localparam int MUL_W = 26;
   localparam int SUM_W = 44;

   typedef enum logic [MODE_W-1:0] {
      MODE_SETVOX = 4'd0,
      MODE_CLRVOX = 4'd1,
      MODE_SETBOX = 4'd2,
      MODE_CLRBOX = 4'd3,
      MODE_SETELL = 4'd4,
      MODE_CLRELL = 4'd5,
      MODE_SETSPH = 4'd6,
      MODE_CLRSPH = 4'd7,
      MODE_READ   = 4'd8
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_type;

   localparam rgba_type RGBA_RESET = '{8'd128, 8'd128, 8'd128, 8'd128};

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic signed [COORD_W-1:0]  first_x;
      logic signed [COORD_W-1:0]  first_y;
      logic signed [COORD_W-1:0]  first_z;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic signed [COORD_W-1:0]  end_z;
      logic [RADIUS_W-1:0]        radius_x;
      logic [RADIUS_W-1:0]        radius_y;
      logic [RADIUS_W-1:0]        radius_z;
   } req_type;

   typedef struct packed {
      logic              voxel_on;
      logic [CHAN_W-1:0] voxel_red;
      logic [CHAN_W-1:0] voxel_green;
      logic [CHAN_W-1:0] voxel_blue;
      logic [CHAN_W-1:0] voxel_alpha;
      logic              out_of_grid;
   } rsp_type;

   typedef struct packed {
      logic     en;
      logic     on;
      logic     col_en;
      rgba_type col;
   } wr_cmd_type;

endpackage

`default_nettype wire

// ----- src/vss_if.sv -----
`default_nettype none

interface vss_req_if;
   logic             valid;
   logic             ready;
   vss_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vss_rsp_if;
   logic             valid;
   logic             ready;
   vss_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/vss_store.sv -----
`default_nettype none

module vss_store #(
   parameter int ADDR_W = vss_pkg::ADDR_W_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic [ADDR_W-1:0]   addr,
   input  wire vss_pkg::wr_cmd_type wr,
   output vss_pkg::rgba_type        rd_col,
   output logic                     rd_on
);

   localparam int DEPTH = 1 << ADDR_W;

   logic              on_mem  [DEPTH];
   vss_pkg::rgba_type col_mem [DEPTH];

   logic              rd_on_ff;
   vss_pkg::rgba_type rd_col_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         on_mem[addr] <= wr.on;
      end
      rd_on_ff <= on_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.col_en) begin
         col_mem[addr] <= wr.col;
      end
      rd_col_ff <= col_mem[addr];
   end

   assign rd_on  = rd_on_ff;
   assign rd_col = rd_col_ff;

endmodule

`default_nettype wire

// ----- src/vss_engine.sv -----
`default_nettype none

module vss_engine #(
   parameter int GRID_X = vss_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = vss_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = vss_pkg::GRID_Z_DEFAULT,
   parameter int ADDR_W = vss_pkg::ADDR_W_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   vss_req_if.sink                  req_bus,
   vss_rsp_if.source                rsp_bus,
   input  wire vss_pkg::rgba_type   paint,
   output logic [ADDR_W-1:0]        mem_addr,
   output vss_pkg::wr_cmd_type      mem_wr,
   input  wire vss_pkg::rgba_type   mem_rd_col,
   input  wire logic                mem_rd_on
);

   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);
   localparam int MUL_W = vss_pkg::MUL_W;
   localparam int SUM_W = vss_pkg::SUM_W;
   localparam int CMP_W = vss_pkg::CMP_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VOX,
      ST_RDWAIT,
      ST_SETUP,
      ST_SUM,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      S_AX, S_AY, S_AZ, S_PYZ, S_PXZ, S_PXY, S_LIM, S_SX,
      S_SY, S_SZ, S_TX, S_TY, S_TZ, S_DX, S_DY, S_DZ
   } step_type;

   function automatic logic signed [MUL_W-1:0] one_minus_2f(
      input logic signed [vss_pkg::COORD_W-1:0] f
   );
      logic signed [MUL_W-1:0] fe;
      fe = MUL_W'(f);
      return MUL_W'(1) - (fe <<< 1);
   endfunction

   state_type         state_ff;
   step_type          step_ff;
   vss_pkg::req_type  cmd_ff;
   vss_pkg::rsp_type  res_ff;
   vss_pkg::rsp_type  rsp_payload_ff;
   logic              rsp_valid_ff;
   logic [XW-1:0]     ix_ff;
   logic [YW-1:0]     iy_ff;
   logic [ZW-1:0]     iz_ff;

   logic signed [MUL_W-1:0] ax_ff, ay_ff, az_ff, pyz_ff, pxz_ff, pxy_ff;
   logic signed [MUL_W-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [SUM_W-1:0] lim_ff, ty0_ff, tz0_ff, dy0_ff, dz0_ff;
   logic signed [SUM_W-1:0] xb_ff, dx_ff, txy_ff, dy_ff, tz_ff, dz_ff;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic signed [SUM_W-1:0]   quad_sum, xb_next;
   logic signed [CMP_W-1:0]   cx, cy, cz;
   logic                      sph, is_box, set_op, in_grid, box_hit, hit;
   logic                      last_x, last_y, last_z, sweep_last;
   vss_pkg::mode_type         req_mode;
   logic [ADDR_W-1:0]         cmd_addr, cnt_addr;

   assign req_mode = vss_pkg::mode_type'(req_bus.payload.mode);
   assign sph      = (cmd_ff.mode == vss_pkg::MODE_SETSPH)
                     || (cmd_ff.mode == vss_pkg::MODE_CLRSPH);
   assign is_box   = (cmd_ff.mode == vss_pkg::MODE_SETBOX)
                     || (cmd_ff.mode == vss_pkg::MODE_CLRBOX);
   assign set_op   = !cmd_ff.mode[0];

   assign in_grid = !cmd_ff.first_x[vss_pkg::COORD_W-1]
                    && !cmd_ff.first_y[vss_pkg::COORD_W-1]
                    && !cmd_ff.first_z[vss_pkg::COORD_W-1]
                    && ($unsigned(cmd_ff.first_x) < vss_pkg::COORD_W'(GRID_X))
                    && ($unsigned(cmd_ff.first_y) < vss_pkg::COORD_W'(GRID_Y))
                    && ($unsigned(cmd_ff.first_z) < vss_pkg::COORD_W'(GRID_Z));

   assign cmd_addr = ADDR_W'({cmd_ff.first_x[XW-1:0], cmd_ff.first_y[YW-1:0],
                              cmd_ff.first_z[ZW-1:0]});
   assign cnt_addr = ADDR_W'({ix_ff, iy_ff, iz_ff});

   assign cx = $signed(CMP_W'(ix_ff));
   assign cy = $signed(CMP_W'(iy_ff));
   assign cz = $signed(CMP_W'(iz_ff));

   assign box_hit = (cx >= CMP_W'(cmd_ff.first_x)) && (cx < CMP_W'(cmd_ff.end_x))
                    && (cy >= CMP_W'(cmd_ff.first_y)) && (cy < CMP_W'(cmd_ff.end_y))
                    && (cz >= CMP_W'(cmd_ff.first_z)) && (cz < CMP_W'(cmd_ff.end_z));

   assign quad_sum = txy_ff + tz_ff;
   assign hit      = is_box ? box_hit : (quad_sum < lim_ff);
   assign xb_next  = xb_ff + dx_ff;

   assign last_x     = (ix_ff == XW'(GRID_X - 1));
   assign last_y     = (iy_ff == YW'(GRID_Y - 1));
   assign last_z     = (iz_ff == ZW'(GRID_Z - 1));
   assign sweep_last = last_x && last_y && last_z;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         S_AX:  begin mul_a = $signed(MUL_W'(cmd_ff.radius_x));
                      mul_b = $signed(MUL_W'(cmd_ff.radius_x)); end
         S_AY:  begin mul_a = $signed(MUL_W'(cmd_ff.radius_y));
                      mul_b = $signed(MUL_W'(cmd_ff.radius_y)); end
         S_AZ:  begin mul_a = $signed(MUL_W'(cmd_ff.radius_z));
                      mul_b = $signed(MUL_W'(cmd_ff.radius_z)); end
         S_PYZ: begin mul_a = sph ? MUL_W'(1) : ay_ff;  mul_b = sph ? MUL_W'(1) : az_ff; end
         S_PXZ: begin mul_a = sph ? MUL_W'(1) : ax_ff;  mul_b = sph ? MUL_W'(1) : az_ff; end
         S_PXY: begin mul_a = sph ? MUL_W'(1) : ax_ff;  mul_b = sph ? MUL_W'(1) : ay_ff; end
         S_LIM: begin mul_a = sph ? ax_ff : pxy_ff;     mul_b = sph ? MUL_W'(1) : az_ff; end
         S_SX:  begin mul_a = MUL_W'(cmd_ff.first_x);   mul_b = MUL_W'(cmd_ff.first_x); end
         S_SY:  begin mul_a = MUL_W'(cmd_ff.first_y);   mul_b = MUL_W'(cmd_ff.first_y); end
         S_SZ:  begin mul_a = MUL_W'(cmd_ff.first_z);   mul_b = MUL_W'(cmd_ff.first_z); end
         S_TX:  begin mul_a = sx_ff; mul_b = pyz_ff; end
         S_TY:  begin mul_a = sy_ff; mul_b = pxz_ff; end
         S_TZ:  begin mul_a = sz_ff; mul_b = pxy_ff; end
         S_DX:  begin mul_a = one_minus_2f(cmd_ff.first_x); mul_b = pyz_ff; end
         S_DY:  begin mul_a = one_minus_2f(cmd_ff.first_y); mul_b = pxz_ff; end
         S_DZ:  begin mul_a = one_minus_2f(cmd_ff.first_z); mul_b = pxy_ff; end
      endcase
   end

   assign prod = mul_a * mul_b;

   // store port
   always_comb begin
      mem_addr   = cnt_addr;
      mem_wr.en  = 1'b0;
      mem_wr.on  = set_op;
      mem_wr.col_en = set_op;
      mem_wr.col = paint;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.en     = 1'b1;
            mem_wr.on     = 1'b0;
            mem_wr.col_en = 1'b1;
            mem_wr.col    = vss_pkg::RGBA_RESET;
         end
         ST_VOX, ST_RDWAIT: begin
            mem_addr  = cmd_addr;
            mem_wr.en = (state_ff == ST_VOX) && in_grid
                        && (cmd_ff.mode != vss_pkg::MODE_READ);
         end
         ST_SWEEP: mem_wr.en = hit;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= S_AX;
         rsp_valid_ff <= 1'b0;
         ix_ff        <= '0;
         iy_ff        <= '0;
         iz_ff        <= '0;
      end else begin
         if (rsp_bus.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (sweep_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_bus.valid) begin
                  cmd_ff <= req_bus.payload;
                  res_ff <= '0;
                  unique case (req_mode) inside
                     vss_pkg::MODE_SETVOX, vss_pkg::MODE_CLRVOX, vss_pkg::MODE_READ:
                        state_ff <= ST_VOX;
                     vss_pkg::MODE_SETBOX, vss_pkg::MODE_CLRBOX:
                        state_ff <= ST_SWEEP;
                     vss_pkg::MODE_SETELL, vss_pkg::MODE_CLRELL: begin
                        if ((req_bus.payload.radius_x == '0)
                            || (req_bus.payload.radius_y == '0)
                            || (req_bus.payload.radius_z == '0)) begin
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_SETUP;
                        end
                     end
                     vss_pkg::MODE_SETSPH, vss_pkg::MODE_CLRSPH: begin
                        state_ff <= (req_bus.payload.radius_x == '0) ? ST_DONE : ST_SETUP;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_VOX: begin
               if (!in_grid) begin
                  res_ff.out_of_grid <= 1'b1;
                  state_ff <= ST_DONE;
               end else if (cmd_ff.mode == vss_pkg::MODE_READ) begin
                  state_ff <= ST_RDWAIT;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_RDWAIT: begin
               res_ff.voxel_on    <= mem_rd_on;
               res_ff.voxel_red   <= mem_rd_col.red;
               res_ff.voxel_green <= mem_rd_col.green;
               res_ff.voxel_blue  <= mem_rd_col.blue;
               res_ff.voxel_alpha <= mem_rd_col.alpha;
               state_ff <= ST_DONE;
            end
            ST_SETUP: begin
               step_ff <= step_type'(step_ff + 4'd1);
               if (step_ff == S_DZ) state_ff <= ST_SUM;
            end
            ST_SUM: begin
               xb_ff    <= xb_ff + ty0_ff;
               txy_ff   <= xb_ff + ty0_ff;
               dy_ff    <= dy0_ff;
               tz_ff    <= tz0_ff;
               dz_ff    <= dz0_ff;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (sweep_last) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_payload_ff <= res_ff;
                  state_ff       <= ST_IDLE;
               end
            end
         endcase

         if (state_ff == ST_SETUP) begin
            unique case (step_ff)
               S_AX:  ax_ff  <= $signed(prod[MUL_W-1:0]);
               S_AY:  ay_ff  <= $signed(prod[MUL_W-1:0]);
               S_AZ:  az_ff  <= $signed(prod[MUL_W-1:0]);
               S_PYZ: pyz_ff <= $signed(prod[MUL_W-1:0]);
               S_PXZ: pxz_ff <= $signed(prod[MUL_W-1:0]);
               S_PXY: pxy_ff <= $signed(prod[MUL_W-1:0]);
               S_LIM: lim_ff <= $signed(prod[SUM_W-1:0]);
               S_SX:  sx_ff  <= $signed(prod[MUL_W-1:0]);
               S_SY:  sy_ff  <= $signed(prod[MUL_W-1:0]);
               S_SZ:  sz_ff  <= $signed(prod[MUL_W-1:0]);
               S_TX:  xb_ff  <= $signed(prod[SUM_W-1:0]);
               S_TY:  ty0_ff <= $signed(prod[SUM_W-1:0]);
               S_TZ:  tz0_ff <= $signed(prod[SUM_W-1:0]);
               S_DX:  dx_ff  <= $signed(prod[SUM_W-1:0]);
               S_DY:  dy0_ff <= $signed(prod[SUM_W-1:0]);
               S_DZ:  dz0_ff <= $signed(prod[SUM_W-1:0]);
            endcase
         end

         // x outer, z inner; quadric terms advance by forward differences
         if ((state_ff == ST_SWEEP) || (state_ff == ST_CLEAR)) begin
            if (last_z) begin
               iz_ff <= '0;
               tz_ff <= tz0_ff;
               dz_ff <= dz0_ff;
               if (last_y) begin
                  iy_ff  <= '0;
                  dy_ff  <= dy0_ff;
                  xb_ff  <= xb_next;
                  txy_ff <= xb_next;
                  dx_ff  <= dx_ff + (SUM_W'(pyz_ff) <<< 1);
                  ix_ff  <= last_x ? '0 : ix_ff + 1'b1;
               end else begin
                  iy_ff  <= iy_ff + 1'b1;
                  txy_ff <= txy_ff + dy_ff;
                  dy_ff  <= dy_ff + (SUM_W'(pxz_ff) <<< 1);
               end
            end else begin
               iz_ff <= iz_ff + 1'b1;
               tz_ff <= tz_ff + dz_ff;
               dz_ff <= dz_ff + (SUM_W'(pxy_ff) <<< 1);
            end
         end
      end
   end

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ----- src/voxel_shape_stamper_top.sv -----
`default_nettype none

// Voxel grid rasterizer: a GRID_X x GRID_Y x GRID_Z store of voxels, each an on bit plus
// an RGBA color, changed by one command word at a time and answered by exactly one
// response word. After reset a clearing pass over all GRID_X*GRID_Y*GRID_Z voxels
// (32768 at the default size) runs with req ready low; paint registers may be written
// during it. A single-voxel set or clear goes through VOX and DONE, a read through
// VOX, RDWAIT and DONE, an unused mode or a zero-radius ellipsoid or sphere straight
// to DONE. A box sweeps the grid; an ellipsoid or sphere first runs a setup sequence
// on the one shared multiplier, then sweeps. Each sweep visits every voxel once, one
// voxel per cycle, bounded by the single write port of the voxel store. One command
// is in work at a time; a new one is taken while the previous response waits on rsp.

module voxel_shape_stamper_top #(
   parameter int GRID_X = vss_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = vss_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = vss_pkg::GRID_Z_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   vss_req_if.sink                              req_bus,
   vss_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_wr_en,
   input  wire logic [vss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vss_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(GRID_X) + $clog2(GRID_Y) + $clog2(GRID_Z);

   typedef enum logic [vss_pkg::CSR_INDEX_W-1:0] {
      CSR_RED   = 3'd0,
      CSR_GREEN = 3'd1,
      CSR_BLUE  = 3'd2,
      CSR_ALPHA = 3'd3
   } csr_index_type;

   vss_pkg::rgba_type   paint_ff;
   logic [ADDR_W-1:0]   mem_addr;
   vss_pkg::wr_cmd_type mem_wr;
   vss_pkg::rgba_type   mem_rd_col;
   logic                mem_rd_on;

   always_ff @(posedge clock) begin
      if (reset) begin
         paint_ff <= vss_pkg::RGBA_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED:   paint_ff.red   <= csr_data;
            CSR_GREEN: paint_ff.green <= csr_data;
            CSR_BLUE:  paint_ff.blue  <= csr_data;
            CSR_ALPHA: paint_ff.alpha <= csr_data;
            default: ;
         endcase
      end
   end

   vss_engine #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z),
      .ADDR_W (ADDR_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .paint      (paint_ff),
      .mem_addr   (mem_addr),
      .mem_wr     (mem_wr),
      .mem_rd_col (mem_rd_col),
      .mem_rd_on  (mem_rd_on)
   );

   vss_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock  (clock),
      .addr   (mem_addr),
      .wr     (mem_wr),
      .rd_col (mem_rd_col),
      .rd_on  (mem_rd_on)
   );

endmodule

`default_nettype wire

// ----- src/vss_checker.sv -----
`default_nettype none

module vss_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire vss_pkg::rsp_type rsp_payload
);

   // clearing pass holds off commands
   a_reset_not_ready: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req ready right after reset");

   // one command in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready in the cycle after an accepted word");

   a_oog_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.out_of_grid) |->
         (!rsp_payload.voxel_on && (rsp_payload.voxel_red == '0)
          && (rsp_payload.voxel_green == '0) && (rsp_payload.voxel_blue == '0)
          && (rsp_payload.voxel_alpha == '0)))
      else $error("out of grid response carries voxel data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("rsp word dropped or changed while stalled");

endmodule

bind voxel_shape_stamper_top vss_checker u_vss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

`default_nettype wire

// ----- bench/tb_voxel_shape_stamper_top.sv -----
module tb_voxel_shape_stamper_top;

   localparam int GRID_X        = vss_pkg::GRID_X_DEFAULT;
   localparam int GRID_Y        = vss_pkg::GRID_Y_DEFAULT;
   localparam int GRID_Z        = vss_pkg::GRID_Z_DEFAULT;
   localparam int CELLS         = GRID_X * GRID_Y * GRID_Z;
   localparam int IDLE_LIMIT    = 150000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;

   localparam logic [vss_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = vss_pkg::MODE_READ + 1;
   localparam logic [vss_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = '1;

   localparam logic [vss_pkg::CSR_INDEX_W-1:0] PAINT_RED   = 3'd0;
   localparam logic [vss_pkg::CSR_INDEX_W-1:0] PAINT_GREEN = 3'd1;
   localparam logic [vss_pkg::CSR_INDEX_W-1:0] PAINT_BLUE  = 3'd2;
   localparam logic [vss_pkg::CSR_INDEX_W-1:0] PAINT_ALPHA = 3'd3;
   localparam logic [vss_pkg::CSR_INDEX_W-1:0] PAINT_NONE  = '1;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [vss_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [vss_pkg::CSR_DATA_W-1:0]  csr_data;

   vss_req_if req_chan ();
   vss_rsp_if rsp_chan ();

   voxel_shape_stamper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_chan),
      .rsp_bus   (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // shadow of the voxel store and paint registers
   logic              voxel_lit   [CELLS];
   vss_pkg::rgba_type voxel_shade [CELLS];
   vss_pkg::rgba_type paint_now;

   vss_pkg::req_type  pending_cmds [$];
   vss_pkg::rsp_type  expected_words [$];
   vss_pkg::rsp_type  want_word;

   int errors;
   int queued_total;
   int answered_total;
   int read_total;
   int shape_total;
   int setting_total;
   int idle_cycles;
   int send_gap;
   int stall_left;
   int shapes_left;
   bit calm;

   function automatic int cell_addr(int x, int y, int z);
      return (x * GRID_Y + y) * GRID_Z + z;
   endfunction

   function automatic int clamp_axis(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void mark_cell(int a, bit set_op);
      if (set_op) begin
         voxel_lit[a]   = 1'b1;
         voxel_shade[a] = paint_now;
      end else begin
         voxel_lit[a] = 1'b0;
      end
   endfunction

   function automatic vss_pkg::rsp_type stamp_command(vss_pkg::req_type c);
      vss_pkg::rsp_type r;
      int      fx, fy, fz, ex, ey, ez;
      int      x0, x1, y0, y1, z0, z1;
      int      i, j, k, a;
      longint  dx, dy, dz, ax, ay, az, lim, s;
      bit      set_op;
      r      = '0;
      fx     = $signed(c.first_x);
      fy     = $signed(c.first_y);
      fz     = $signed(c.first_z);
      ex     = $signed(c.end_x);
      ey     = $signed(c.end_y);
      ez     = $signed(c.end_z);
      ax     = c.radius_x;
      ay     = c.radius_y;
      az     = c.radius_z;
      set_op = ~c.mode[0];
      case (c.mode)
         vss_pkg::MODE_SETVOX, vss_pkg::MODE_CLRVOX, vss_pkg::MODE_READ: begin
            if (fx < 0 || fx >= GRID_X || fy < 0 || fy >= GRID_Y || fz < 0 || fz >= GRID_Z) begin
               r.out_of_grid = 1'b1;
            end else begin
               a = cell_addr(fx, fy, fz);
               if (c.mode == vss_pkg::MODE_READ) begin
                  r.voxel_on    = voxel_lit[a];
                  r.voxel_red   = voxel_shade[a].red;
                  r.voxel_green = voxel_shade[a].green;
                  r.voxel_blue  = voxel_shade[a].blue;
                  r.voxel_alpha = voxel_shade[a].alpha;
               end else begin
                  mark_cell(a, set_op);
               end
            end
         end
         vss_pkg::MODE_SETBOX, vss_pkg::MODE_CLRBOX: begin
            x0 = clamp_axis(fx, GRID_X);
            x1 = clamp_axis(ex, GRID_X);
            y0 = clamp_axis(fy, GRID_Y);
            y1 = clamp_axis(ey, GRID_Y);
            z0 = clamp_axis(fz, GRID_Z);
            z1 = clamp_axis(ez, GRID_Z);
            for (i = x0; i < x1; i++)
               for (j = y0; j < y1; j++)
                  for (k = z0; k < z1; k++)
                     mark_cell(cell_addr(i, j, k), set_op);
         end
         vss_pkg::MODE_SETELL, vss_pkg::MODE_CLRELL: begin
            if (ax != 0 && ay != 0 && az != 0) begin
               ax  = ax * ax;
               ay  = ay * ay;
               az  = az * az;
               lim = ax * ay * az;
               for (i = 0; i < GRID_X; i++)
                  for (j = 0; j < GRID_Y; j++)
                     for (k = 0; k < GRID_Z; k++) begin
                        dx = i - fx;
                        dy = j - fy;
                        dz = k - fz;
                        s  = dx * dx * ay * az + dy * dy * ax * az + dz * dz * ax * ay;
                        if (s < lim) mark_cell(cell_addr(i, j, k), set_op);
                     end
            end
         end
         vss_pkg::MODE_SETSPH, vss_pkg::MODE_CLRSPH: begin
            lim = ax * ax;
            for (i = 0; i < GRID_X; i++)
               for (j = 0; j < GRID_Y; j++)
                  for (k = 0; k < GRID_Z; k++) begin
                     dx = i - fx;
                     dy = j - fy;
                     dz = k - fz;
                     if (dx * dx + dy * dy + dz * dz < lim) mark_cell(cell_addr(i, j, k), set_op);
                  end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_cmd(input logic [vss_pkg::MODE_W-1:0] m,
                            input int fx, input int fy, input int fz,
                            input int ex, input int ey, input int ez,
                            input int rx, input int ry, input int rz);
      vss_pkg::req_type c;
      c.mode     = m;
      c.first_x  = fx[7:0];
      c.first_y  = fy[7:0];
      c.first_z  = fz[7:0];
      c.end_x    = ex[7:0];
      c.end_y    = ey[7:0];
      c.end_z    = ez[7:0];
      c.radius_x = rx[5:0];
      c.radius_y = ry[5:0];
      c.radius_z = rz[5:0];
      pending_cmds.push_back(c);
      queued_total++;
      if (m == vss_pkg::MODE_READ) read_total++;
      if (m >= vss_pkg::MODE_SETBOX && m <= vss_pkg::MODE_CLRSPH) shape_total++;
   endtask

   task automatic queue_at(input logic [vss_pkg::MODE_W-1:0] m,
                           input int x, input int y, input int z);
      queue_cmd(m, x, y, z, 0, 0, 0, 0, 0, 0);
   endtask

   function automatic int rand_byte();
      return $signed(8'($urandom_range(0, 255)));
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, GRID_X - 1);
      return rand_byte();
   endfunction

   function automatic int rand_radius();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 63);
      return $urandom_range(1, 14);
   endfunction

   // a shape followed by reads around it, or a single-voxel word, or noise
   task automatic queue_random_burst();
      int                         pick, kind, clr, cx, cy, cz, spread;
      logic [vss_pkg::MODE_W-1:0] m;
      pick = $urandom_range(0, 99);
      clr  = $urandom_range(0, 1);
      if (pick < 15 && shapes_left > 0) begin
         shapes_left--;
         cx   = int'($urandom_range(0, 40)) - 4;
         cy   = int'($urandom_range(0, 40)) - 4;
         cz   = int'($urandom_range(0, 40)) - 4;
         kind = $urandom_range(0, 2);
         if (kind == 0) begin
            spread = $urandom_range(1, 16);
            if ($urandom_range(0, 5) == 0)
               queue_cmd(4'(vss_pkg::MODE_SETBOX + clr), rand_byte(), rand_byte(), rand_byte(),
                         rand_byte(), rand_byte(), rand_byte(),
                         $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
            else
               queue_cmd(4'(vss_pkg::MODE_SETBOX + clr), cx, cy, cz, cx + spread,
                         cy + int'($urandom_range(1, 16)), cz + int'($urandom_range(1, 16)),
                         $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (kind == 1) begin
            spread = 14;
            queue_cmd(4'(vss_pkg::MODE_SETELL + clr), cx, cy, cz,
                      rand_byte(), rand_byte(), rand_byte(),
                      rand_radius(), rand_radius(), rand_radius());
         end else begin
            spread = rand_radius();
            queue_cmd(4'(vss_pkg::MODE_SETSPH + clr), cx, cy, cz,
                      rand_byte(), rand_byte(), rand_byte(),
                      spread, $urandom_range(0, 63), $urandom_range(0, 63));
         end
         repeat (3)
            queue_at(vss_pkg::MODE_READ,
                     cx + int'($urandom_range(0, 2 * spread + 2)) - spread - 1,
                     cy + int'($urandom_range(0, 2 * spread + 2)) - spread - 1,
                     cz + int'($urandom_range(0, 2 * spread + 2)) - spread - 1);
      end else if (pick < 60) begin
         queue_at(vss_pkg::MODE_READ, rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 90) begin
         queue_at(4'(vss_pkg::MODE_SETVOX + clr), rand_coord(), rand_coord(), rand_coord());
      end else begin
         case ($urandom_range(0, 2))
            0:       m = vss_pkg::MODE_SETVOX;
            1:       m = vss_pkg::MODE_CLRVOX;
            default: m = 4'($urandom_range(vss_pkg::MODE_READ, MODE_UNUSED_LAST));
         endcase
         queue_cmd(m, rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
      end
   endtask

   task automatic queue_random_part(input int count);
      int target;
      target = queued_total + count;
      while (queued_total < target) queue_random_burst();
   endtask

   task automatic write_paint(input logic [vss_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [vss_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         PAINT_RED:   paint_now.red   = val;
         PAINT_GREEN: paint_now.green = val;
         PAINT_BLUE:  paint_now.blue  = val;
         PAINT_ALPHA: paint_now.alpha = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (answered_total != queued_total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t error: %s expected %0d got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_words.push_back(stamp_command(req_chan.payload));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap       <= $urandom_range(0, 13);
               req_chan.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_chan.payload <= pending_cmds.pop_front();
               req_chan.valid   <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            answered_total++;
            if (expected_words.size() == 0) begin
               $display("%0t error: expected no word got %p", $time, rsp_chan.payload);
               errors++;
            end else begin
               want_word = expected_words.pop_front();
               check_field("voxel_on", want_word.voxel_on, rsp_chan.payload.voxel_on);
               check_field("voxel_red", want_word.voxel_red, rsp_chan.payload.voxel_red);
               check_field("voxel_green", want_word.voxel_green, rsp_chan.payload.voxel_green);
               check_field("voxel_blue", want_word.voxel_blue, rsp_chan.payload.voxel_blue);
               check_field("voxel_alpha", want_word.voxel_alpha, rsp_chan.payload.voxel_alpha);
               check_field("out_of_grid", want_word.out_of_grid, rsp_chan.payload.out_of_grid);
            end
         end
         if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left     <= $urandom_range(0, 13);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      calm             = 1'b0;
      shapes_left      = 12;
      setting_total    = 1;
      paint_now        = vss_pkg::RGBA_RESET;
      for (int a = 0; a < CELLS; a++) begin
         voxel_lit[a]   = 1'b0;
         voxel_shade[a] = vss_pkg::RGBA_RESET;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset paint, single voxels, out-of-grid and unused modes
      queue_at(vss_pkg::MODE_READ, 0, 0, 0);
      queue_at(vss_pkg::MODE_SETVOX, 31, 31, 31);
      queue_at(vss_pkg::MODE_READ, 31, 31, 31);
      queue_at(vss_pkg::MODE_SETVOX, 32, 0, 0);
      queue_at(vss_pkg::MODE_READ, -1, 5, 5);
      queue_at(vss_pkg::MODE_CLRVOX, 0, 0, -128);
      queue_cmd(MODE_UNUSED_FIRST, 1, 2, 3, 4, 5, 6, 7, 8, 9);
      queue_cmd(MODE_UNUSED_LAST, -128, 127, -1, -128, 127, -1, 63, 63, 63);
      queue_at(vss_pkg::MODE_CLRVOX, 31, 31, 31);
      queue_at(vss_pkg::MODE_READ, 31, 31, 31);
      wait_drained();

      write_paint(PAINT_RED, 8'd255);
      write_paint(PAINT_GREEN, 8'd0);
      write_paint(PAINT_BLUE, 8'd255);
      write_paint(PAINT_ALPHA, 8'd0);
      write_paint(PAINT_NONE, 8'h5a);
      setting_total++;

      // boxes, ellipsoid boundary, zero radii, clipped sphere
      queue_cmd(vss_pkg::MODE_SETBOX, -128, -128, -128, 127, 127, 127, 0, 0, 0);
      queue_cmd(vss_pkg::MODE_CLRBOX, 4, 4, 4, 8, 8, 8, 0, 0, 0);
      queue_at(vss_pkg::MODE_READ, 4, 4, 4);
      queue_at(vss_pkg::MODE_READ, 8, 8, 8);
      queue_cmd(vss_pkg::MODE_SETBOX, 10, 10, 10, 10, 20, 20, 0, 0, 0);
      queue_cmd(vss_pkg::MODE_CLRELL, 16, 16, 16, 0, 0, 0, 10, 5, 3);
      queue_at(vss_pkg::MODE_READ, 16, 16, 19);
      queue_at(vss_pkg::MODE_READ, 16, 16, 18);
      queue_cmd(vss_pkg::MODE_SETELL, 16, 16, 16, 0, 0, 0, 63, 63, 0);
      queue_at(vss_pkg::MODE_READ, 16, 16, 16);
      queue_cmd(vss_pkg::MODE_CLRSPH, -2, -2, -2, 0, 0, 0, 5, 0, 0);
      queue_at(vss_pkg::MODE_READ, 0, 0, 0);
      queue_cmd(vss_pkg::MODE_SETSPH, 16, 16, 16, 0, 0, 0, 63, 0, 0);
      queue_cmd(vss_pkg::MODE_CLRSPH, 16, 16, 16, 0, 0, 0, 0, 0, 0);
      queue_at(vss_pkg::MODE_READ, 5, 6, 7);
      wait_drained();

      write_paint(PAINT_RED, 8'd0);
      write_paint(PAINT_GREEN, 8'd255);
      write_paint(PAINT_BLUE, 8'd0);
      write_paint(PAINT_ALPHA, 8'd255);
      setting_total++;
      queue_random_part(30);
      wait_drained();

      write_paint(PAINT_RED, 8'($urandom_range(0, 255)));
      write_paint(PAINT_GREEN, 8'($urandom_range(0, 255)));
      write_paint(PAINT_BLUE, 8'($urandom_range(0, 255)));
      write_paint(PAINT_ALPHA, 8'($urandom_range(0, 255)));
      setting_total++;
      queue_random_part(30);
      wait_drained();

      calm = 1'b1;
      queue_random_part(15);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d command words (%0d reads, %0d shapes) under %0d paint settings.",
               queued_total, read_total, shape_total, setting_total);
      $display("Checked %0d response words, %0d errors.", answered_total, errors);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
